/* design/matrix_vector_multiply_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block
// Checks are compiled in unless ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF
// Concurrent check on clk_i, quiet while rst_ni is low
`define MVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen at a clock edge
`define MVM_ASSERT_NEVER(label, cond, msg) \
  `MVM_ASSERT(label, !(cond), msg)
`else
`define MVM_ASSERT(label, prop, msg)
`define MVM_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* design/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared widths, register indexes and beat types of the GEMV block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned RowIdxW  = 16;
  localparam int unsigned ColsCfgW = 13;
  localparam int unsigned RowsCfgW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned ResetColsInUse = 64;
  localparam int unsigned ResetRowsInUse = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegColsInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRowsInUse = 2'd1;

  typedef enum logic {
    FuncLoad   = 1'b0,
    FuncWeight = 1'b1
  } func_e;

  // Classified operation handed from front to back
  typedef struct packed {
    logic                     is_load;
    logic                     end_row;
    logic                     last_row;
    logic [RowIdxW-1:0]       row_index;
    logic signed [ValueW-1:0] value;
  } op_t;

  // One row result
  typedef struct packed {
    logic signed [AccW-1:0] row_value;
    logic [RowIdxW-1:0]     row_index;
    logic                   last_row;
  } res_t;

endpackage

/* design/mvm_fifo.sv */
// ----------------------------------------------------------------------------
// mvm_fifo
// Small register queue with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module mvm_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [DATA_W-1:0]              data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [DATA_W-1:0]              data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* design/mvm_front.sv */
// ----------------------------------------------------------------------------
// mvm_front
// Accepts input beats, tracks load, column and row positions and
// classifies each beat into an operation for the back end.
// ----------------------------------------------------------------------------
module mvm_front #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_ROWS = 65535
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           func_i,
  input  logic signed [mvm_pkg::ValueW-1:0] value_i,
  input  logic                           q_full_i,
  output logic                           op_push_o,
  output mvm_pkg::op_t                   op_o,
  output logic [$clog2(MAX_COLS)-1:0]    addr_o,
  input  logic                           cfg_valid_i,
  input  logic [mvm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mvm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mvm_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLS);
  localparam int unsigned RowW = $clog2(MAX_ROWS);
  localparam int unsigned CcW  = ($clog2(MAX_COLS + 1) > ColsCfgW) ?
                                 $clog2(MAX_COLS + 1) : ColsCfgW;
  localparam int unsigned RcW  = ($clog2(MAX_ROWS + 1) > RowsCfgW) ?
                                 $clog2(MAX_ROWS + 1) : RowsCfgW;
  localparam logic [ColW-1:0] RstLastCol =
    ColW'(((ResetColsInUse > MAX_COLS) ? MAX_COLS : ResetColsInUse) - 1);
  localparam logic [RowW-1:0] RstLastRow =
    RowW'(((ResetRowsInUse > MAX_ROWS) ? MAX_ROWS : ResetRowsInUse) - 1);

  // Clamp a column count to 1..MAX_COLS and return its last index
  function automatic logic [ColW-1:0] last_col_of(input logic [ColsCfgW-1:0] cfg);
    logic [CcW-1:0] v;
    v = CcW'(cfg);
    if (v == '0) begin
      return '0;
    end else if (v > CcW'(MAX_COLS)) begin
      return ColW'(MAX_COLS - 1);
    end else begin
      return ColW'(v - CcW'(1));
    end
  endfunction

  // Clamp a row count to 1..MAX_ROWS and return its last index
  function automatic logic [RowW-1:0] last_row_of(input logic [RowsCfgW-1:0] cfg);
    logic [RcW-1:0] v;
    v = RcW'(cfg);
    if (v == '0) begin
      return '0;
    end else if (v > RcW'(MAX_ROWS)) begin
      return RowW'(MAX_ROWS - 1);
    end else begin
      return RowW'(v - RcW'(1));
    end
  endfunction

  logic [ColW-1:0] last_col_q;
  logic [RowW-1:0] last_row_q;
  logic [ColW-1:0] load_pos_q, load_pos_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] load_addr;
  logic [RowW+RowIdxW-1:0] row_ext;
  logic            accept;

  assign accept    = push_i && !q_full_i;
  assign op_push_o = accept;
  assign row_ext   = {{RowIdxW{1'b0}}, row_q};

  // Classify the beat and work out the next positions
  always_comb begin
    load_pos_d      = load_pos_q;
    col_d           = col_q;
    row_d           = row_q;
    load_addr       = (load_pos_q > last_col_q) ? '0 : load_pos_q;
    op_o.is_load    = 1'b0;
    op_o.end_row    = 1'b0;
    op_o.last_row   = 1'b0;
    op_o.row_index  = row_ext[RowIdxW-1:0];
    op_o.value      = value_i;
    addr_o          = col_q;
    if (func_i == FuncWeight) begin
      load_pos_d = '0;
      if (col_q >= last_col_q) begin
        op_o.end_row  = 1'b1;
        op_o.last_row = (row_q >= last_row_q);
        col_d         = '0;
        row_d         = (row_q >= last_row_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else begin
      op_o.is_load = 1'b1;
      addr_o       = load_addr;
      load_pos_d   = (load_addr >= last_col_q) ? '0 : load_addr + ColW'(1);
      col_d        = '0;
      row_d        = '0;
    end
  end

  // Hold positions and clamped limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= RstLastCol;
      last_row_q <= RstLastRow;
      load_pos_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegColsInUse: last_col_q <= last_col_of(cfg_data_i[ColsCfgW-1:0]);
          RegRowsInUse: last_row_q <= last_row_of(cfg_data_i[RowsCfgW-1:0]);
          default: ;
        endcase
      end
      if (accept) begin
        load_pos_q <= load_pos_d;
        col_q      <= col_d;
        row_q      <= row_d;
      end
    end
  end

endmodule

/* design/mvm_back.sv */
// ----------------------------------------------------------------------------
// mvm_back
// Executes operations: vector store writes, weight times element
// multiply and accumulate, and row result hand-off to the result queue.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_defines.svh"

module mvm_back #(
  parameter int unsigned MAX_COLS  = 4096,
  parameter int unsigned RES_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_empty_i,
  input  mvm_pkg::op_t                     op_i,
  input  logic [$clog2(MAX_COLS)-1:0]      addr_i,
  output logic                             op_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0]   res_count_i,
  output logic                             res_push_o,
  output mvm_pkg::res_t                    res_o
);
  import mvm_pkg::*;

  localparam int unsigned ResCntW = $clog2(RES_DEPTH + 1);

  logic [ValueW-1:0]        vstore_q [MAX_COLS];
  logic signed [ValueW-1:0] elem_q;
  logic                     s1_v_q, s2_v_q;
  op_t                      s1_op_q, s2_op_q;
  logic signed [ValueW-1:0] mul_a;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [ProdW-1:0]  prod_q;
  logic [AccW-1:0]          acc_q;
  logic [AccW-1:0]          sum;
  logic [ResCntW:0]         in_flight;

  // Pop only when every beat in flight is sure of a result slot
  assign in_flight = (ResCntW + 1)'(res_count_i) + (ResCntW + 1)'(s1_v_q)
                   + (ResCntW + 1)'(s2_v_q);
  assign op_pop_o  = !op_empty_i && (in_flight < (ResCntW + 1)'(RES_DEPTH));

  // Vector store: write on load, registered read on weight
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      if (op_i.is_load) begin
        vstore_q[addr_i] <= op_i.value;
      end else begin
        elem_q <= vstore_q[addr_i];
      end
    end
  end

  // Multiply weight by element
  assign mul_a = s1_op_q.value;
  assign mul_p = mul_a * elem_q;

  // Accumulate the sign-extended product
  assign sum = acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};

  assign res_push_o      = s2_v_q && s2_op_q.end_row && !s2_op_q.is_load;
  assign res_o.row_value = sum;
  assign res_o.row_index = s2_op_q.row_index;
  assign res_o.last_row  = s2_op_q.last_row;

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      s1_op_q <= op_i;
    end
    if (s1_v_q) begin
      s2_op_q <= s1_op_q;
      prod_q  <= mul_p;
    end
  end

  // Pipeline control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      s1_v_q <= op_pop_o;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        if (s2_op_q.is_load || s2_op_q.end_row) begin
          acc_q <= '0;
        end else begin
          acc_q <= sum;
        end
      end
    end
  end

  `MVM_ASSERT(a_res_room, res_push_o |-> (res_count_i < ResCntW'(RES_DEPTH)), "result queue overrun")
  `MVM_ASSERT(a_acc_clear, (s2_v_q && (s2_op_q.is_load || s2_op_q.end_row)) |=> (acc_q == '0), "sum not cleared")
  `MVM_ASSERT(a_s2_from_s1, s2_v_q |-> $past(s1_v_q), "stage two valid without stage one")
  `MVM_ASSERT_NEVER(a_pop_empty, op_pop_o && op_empty_i, "operation popped from empty queue")

endmodule

/* design/matrix_vector_multiply.sv */
// Path: a row's last weight passes the op queue, s1 and s2, then the result queue.
// Throughput: one beat (load or weight) per cycle while the result side keeps popping;
//   the single multiply-accumulate into the running sum sets that figure.
// Reset: positions, sum and queues clear at once; the vector store is not cleared,
//   so no clearing pass is needed and beats are accepted straight after reset.
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// GEMV over a stored Q4.12 vector with a Q24.24 row sum; front classifies
// beats, a short queue decouples it from the multiply-accumulate back end.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_ROWS = 65535
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  logic                                func_i,
  input  logic signed [mvm_pkg::ValueW-1:0]   value_i,
  output logic                                full,
  output logic signed [mvm_pkg::AccW-1:0]     row_value_o,
  output logic [mvm_pkg::RowIdxW-1:0]         row_index_o,
  output logic                                last_row_o,
  output logic                                empty,
  input  logic                                pop,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mvm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mvm_pkg::CfgDataW-1:0]        cfg_data_i
);
  import mvm_pkg::*;

  localparam int unsigned ColW     = $clog2(MAX_COLS);
  localparam int unsigned OpQDepth = 2;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned OpW      = ColW + $bits(op_t);

  logic                 op_push, op_full, op_pop, op_empty;
  op_t                  front_op, back_op;
  logic [ColW-1:0]      front_addr, back_addr;
  logic [OpW-1:0]       q_rdata;
  logic                 res_push;
  res_t                 res_in, res_out;
  logic [$clog2(ResDepth+1)-1:0] res_count;

  assign cfg_ready_o = 1'b1;
  assign full        = op_full;

  mvm_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .func_i      (func_i),
    .value_i     (value_i),
    .q_full_i    (op_full),
    .op_push_o   (op_push),
    .op_o        (front_op),
    .addr_o      (front_addr),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Operation queue between front and back
  mvm_fifo #(
    .DATA_W (OpW),
    .DEPTH  (OpQDepth)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  ({front_addr, front_op}),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (q_rdata),
    .empty_o (op_empty),
    .count_o ()
  );

  assign {back_addr, back_op} = q_rdata;

  mvm_back #(
    .MAX_COLS  (MAX_COLS),
    .RES_DEPTH (ResDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_empty_i  (op_empty),
    .op_i        (back_op),
    .addr_i      (back_addr),
    .op_pop_o    (op_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue towards the consumer
  mvm_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign row_value_o = res_out.row_value;
  assign row_index_o = res_out.row_index;
  assign last_row_o  = res_out.last_row;

endmodule

/* sim/tb_matrix_vector_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply
// Streams vector loads and weight beats into the GEMV block with random gaps
// on both sides, predicts every row sum in Q24.24, and checks the results
// field by field. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply;
  import mvm_pkg::*;

  localparam int unsigned MaxCols       = 4096;
  localparam int unsigned MaxRows       = 65535;
  localparam int          ClkPeriod     = 12;
  localparam int unsigned IdlePct       = 31;
  localparam int unsigned SettleCycles  = 8;
  localparam int          TimeoutCycles = 1000000;

  // One queued beat: either an item for the data side or a register write
  typedef struct {
    bit                       is_cfg;
    func_e                    func;
    logic signed [ValueW-1:0] value;
    logic [CfgIdxW-1:0]       reg_index;
    logic [CfgDataW-1:0]      reg_data;
  } beat_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       push        = 1'b0;
  logic                       func_i      = 1'b0;
  logic signed [ValueW-1:0]   value_i     = '0;
  logic                       full;
  logic signed [AccW-1:0]     row_value_o;
  logic [RowIdxW-1:0]         row_index_o;
  logic                       last_row_o;
  logic                       empty;
  logic                       pop         = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i  = '0;

  beat_t       beats_to_send [$];
  res_t        rows_due [$];
  int unsigned mismatch_count = 0;

  // Predictor state, advanced as beats are accepted
  logic signed [ValueW-1:0] vec_shadow [MaxCols];
  int unsigned              load_ptr = 0;
  int unsigned              col_ptr  = 0;
  int unsigned              row_ptr  = 0;
  logic signed [AccW-1:0]   row_sum  = '0;
  int unsigned              cols_reg = ResetColsInUse;
  int unsigned              rows_reg = ResetRowsInUse;

  // Planning state: keeps weights away from vector entries never written
  int unsigned plan_cols     = ResetColsInUse;
  int unsigned plan_load_ptr = 0;
  int unsigned plan_hwm      = 0;
  int unsigned plan_items    = 0;

  matrix_vector_multiply #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .func_i     (func_i),
    .value_i    (value_i),
    .full       (full),
    .row_value_o(row_value_o),
    .row_index_o(row_index_o),
    .last_row_o (last_row_o),
    .empty      (empty),
    .pop        (pop),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp_count(int unsigned raw, int unsigned top);
    if (raw < 1) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // Apply a register write to the predictor
  function automatic void write_register(logic [CfgIdxW-1:0] idx,
                                         logic [CfgDataW-1:0] data);
    case (idx)
      RegColsInUse: cols_reg = data[ColsCfgW-1:0];
      RegRowsInUse: rows_reg = data[RowsCfgW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted beat; queue a row sum at row end
  function automatic void accumulate_beat(func_e f, logic signed [ValueW-1:0] v);
    int unsigned            cols;
    int unsigned            rows;
    logic signed [AccW-1:0] prod;
    res_t                   row;
    cols = clamp_count(cols_reg, MaxCols);
    rows = clamp_count(rows_reg, MaxRows);
    if (f == FuncLoad) begin
      if (load_ptr >= cols) load_ptr = 0;
      vec_shadow[load_ptr] = v;
      load_ptr++;
      if (load_ptr >= cols) load_ptr = 0;
      col_ptr = 0;
      row_ptr = 0;
      row_sum = '0;
    end else begin
      load_ptr = 0;
      prod = v * vec_shadow[col_ptr % MaxCols];
      row_sum = row_sum + prod;
      if (col_ptr + 1 >= cols) begin
        row.row_value = row_sum;
        row.row_index = RowIdxW'(row_ptr);
        row.last_row  = (row_ptr + 1 >= rows);
        rows_due.push_back(row);
        row_sum = '0;
        col_ptr = 0;
        row_ptr = row.last_row ? 0 : row_ptr + 1;
      end else begin
        col_ptr++;
      end
    end
  endfunction

  function automatic void queue_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    beat_t b;
    if (idx == RegColsInUse) plan_cols = data[ColsCfgW-1:0];
    b = '{is_cfg: 1'b1, func: FuncLoad, value: '0, reg_index: idx, reg_data: data};
    beats_to_send.push_back(b);
  endfunction

  function automatic void queue_load(logic signed [ValueW-1:0] v);
    int unsigned c;
    beat_t       b;
    c = clamp_count(plan_cols, MaxCols);
    if (plan_load_ptr >= c) plan_load_ptr = 0;
    if (plan_load_ptr + 1 > plan_hwm) plan_hwm = plan_load_ptr + 1;
    plan_load_ptr++;
    if (plan_load_ptr >= c) plan_load_ptr = 0;
    b = '{is_cfg: 1'b0, func: FuncLoad, value: v, reg_index: '0, reg_data: '0};
    beats_to_send.push_back(b);
    plan_items++;
  endfunction

  function automatic void queue_weight(logic signed [ValueW-1:0] v);
    beat_t b;
    plan_load_ptr = 0;
    b = '{is_cfg: 1'b0, func: FuncWeight, value: v, reg_index: '0, reg_data: '0};
    beats_to_send.push_back(b);
    plan_items++;
  endfunction

  function automatic logic signed [ValueW-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      default: return ValueW'($urandom);
    endcase
  endfunction

  function automatic void queue_vector();
    repeat (clamp_count(plan_cols, MaxCols)) queue_load(random_value());
  endfunction

  // One phase: new settings, then mostly whole vectors and rows, some noise
  function automatic void queue_phase(logic [CfgDataW-1:0] cols_word,
                                      logic [CfgDataW-1:0] rows_word,
                                      int unsigned n_items);
    int unsigned c;
    int unsigned first;
    int unsigned pick;
    queue_write(RegColsInUse, cols_word);
    queue_write(RegRowsInUse, rows_word);
    c = clamp_count(plan_cols, MaxCols);
    first = plan_items;
    if (c > plan_hwm || $urandom_range(0, 1) == 0) queue_vector();
    while (plan_items - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (c > plan_hwm || pick < 12) begin
        queue_vector();
      end else if (pick < 22) begin
        repeat ($urandom_range(1, c)) queue_load(random_value());
      end else begin
        repeat ($urandom_range(1, 2 * c + 1)) queue_weight(random_value());
      end
    end
  endfunction

  // Drive beats and register writes from the queue
  always @(posedge clk_i) begin : drive_beats
    int unsigned drive_ticks;
    int unsigned quiet_cycles;
    bit          next_push;
    bit          next_cfg;
    if (rst_ni) begin
      drive_ticks++;
      if (push && !full) begin
        accumulate_beat(beats_to_send[0].func, beats_to_send[0].value);
        void'(beats_to_send.pop_front());
        quiet_cycles = 0;
      end else if (quiet_cycles < SettleCycles) begin
        quiet_cycles++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_register(cfg_index_i, cfg_data_i);
        void'(beats_to_send.pop_front());
      end
      next_push = 1'b0;
      next_cfg  = 1'b0;
      if (beats_to_send.size() != 0) begin
        // hold register writes until the block has drained
        if (beats_to_send[0].is_cfg) begin
          next_cfg = (rows_due.size() == 0 && quiet_cycles >= SettleCycles);
        end else begin
          next_push = ((drive_ticks + 600) % 1000) < 150 ||
                      $urandom_range(0, 99) >= IdlePct;
        end
        func_i      <= beats_to_send[0].func;
        value_i     <= beats_to_send[0].value;
        cfg_index_i <= beats_to_send[0].reg_index;
        cfg_data_i  <= beats_to_send[0].reg_data;
      end
      push        <= next_push;
      cfg_valid_i <= next_cfg;
    end
  end

  // Check each popped row result against the oldest prediction
  always @(posedge clk_i) begin : check_rows
    int unsigned pop_ticks;
    res_t        want;
    if (rst_ni) begin
      pop_ticks++;
      if (pop && !empty) begin
        if (rows_due.size() == 0) begin
          $error("row result with none pending: row_index %0d", row_index_o);
          mismatch_count++;
        end else begin
          want = rows_due.pop_front();
          if (row_value_o !== want.row_value) begin
            $error("row_value: expected %0d, got %0d", want.row_value, row_value_o);
            mismatch_count++;
          end
          if (row_index_o !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, row_index_o);
            mismatch_count++;
          end
          if (last_row_o !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, last_row_o);
            mismatch_count++;
          end
        end
      end
      pop <= ((pop_ticks + 600) % 1000) < 150 || $urandom_range(0, 99) >= IdlePct;
    end
  end

  initial begin : stimulus
    int unsigned p;

    // Directed: four columns, three rows, extreme values
    queue_write(RegColsInUse, 16'd4);
    queue_write(RegRowsInUse, 16'd3);
    queue_load(16'sh8000);
    queue_load(16'sh7FFF);
    queue_load(16'sh0000);
    queue_load(16'shFFFF);
    queue_weight(16'sh8000);
    queue_weight(16'sh7FFF);
    queue_weight(16'sh7FFF);
    queue_weight(16'sh8000);
    queue_weight(16'sh7FFF);
    queue_weight(16'sh8000);
    queue_weight(16'sh1234);
    queue_weight(16'sh0001);
    queue_weight(16'shFFFF);
    queue_weight(16'sh8000);
    queue_weight(16'sh4000);
    // shrink both registers mid-row: the next weight ends the row as the last
    queue_write(RegColsInUse, 16'd2);
    queue_write(RegRowsInUse, 16'd1);
    queue_weight(16'sh7FFF);
    // a weight after a partial load restarts the load position
    queue_load(16'sh1000);
    queue_weight(16'sh0100);
    queue_load(16'sh0C00);
    queue_weight(16'sh8000);
    queue_weight(16'sh7FFF);

    // Random phases over small, zero and full-range register settings
    for (p = 0; p < 12; p++) begin
      case (p)
        0:       queue_phase(16'd0, 16'd0, 36);
        1:       queue_phase(16'd1, 16'd1, 36);
        2:       queue_phase(16'd2, 16'hFFFF, 36);
        3:       queue_phase(16'd7, 16'd65534, 36);
        default: queue_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 36);
      endcase
    end
    queue_phase(16'd3, 16'd2, 30);

    // Drain, then allow for the pipeline before the verdict
    while (beats_to_send.size() != 0 || rows_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles * 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
